// ===== rtl/multitap_stereo_feedback_delay_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the multitap stereo feedback delay
// Concurrent checks on clk, disabled while rst is high.
// ----------------------------------------------------------------------------
`ifndef MULTITAP_STEREO_FEEDBACK_DELAY_ASSERT_SVH
`define MULTITAP_STEREO_FEEDBACK_DELAY_ASSERT_SVH

`ifndef SYNTHESIS
// pre holds -> post holds in the same cycle
`define MSFD_ASSERT_SAME(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("msfd: same-cycle check failed");
// pre holds -> post holds in the next cycle
`define MSFD_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("msfd: next-cycle check failed");
`else
`define MSFD_ASSERT_SAME(lbl, pre, post)
`define MSFD_ASSERT_NEXT(lbl, pre, post)
`endif

`endif

// ===== rtl/msfd_pkg.sv =====
// ----------------------------------------------------------------------------
// msfd_pkg
// Constants, state type and saturation helper for the feedback delay.
// ----------------------------------------------------------------------------
package msfd_pkg;

  localparam int SMP_W      = 24;
  localparam int RING_AW    = 18;
  localparam int RING_DEPTH = 1 << RING_AW;
  localparam int NUM_TAPS   = 4;
  localparam int TAP_IW     = 2;
  localparam int TAP_CW     = 3;
  localparam int CFG_IW     = 4;
  localparam int CFG_DW     = 56;

  localparam logic [CFG_IW-1:0] REG_TAP_COUNT = 4'd0;
  localparam logic [CFG_IW-1:0] REG_TAP_0     = 4'd1;
  localparam logic [CFG_IW-1:0] REG_TAP_3     = 4'd4;
  localparam logic [CFG_IW-1:0] REG_FB_TARGET = 4'd5;
  localparam logic [CFG_IW-1:0] REG_MIX_TARGET = 4'd6;
  localparam logic [CFG_IW-1:0] REG_SMOOTH    = 4'd7;

  localparam logic [15:0] SMOOTH_RESET = 16'd136;

  typedef enum logic [10:0] {
    S_IDLE   = 11'b000_0000_0001,
    S_GLIDE  = 11'b000_0000_0010,
    S_GUPD   = 11'b000_0000_0100,
    S_RD0    = 11'b000_0000_1000,
    S_RD1    = 11'b000_0001_0000,
    S_INTERP = 11'b000_0010_0000,
    S_MAC    = 11'b000_0100_0000,
    S_ACC    = 11'b000_1000_0000,
    S_WET    = 11'b001_0000_0000,
    S_MIX    = 11'b010_0000_0000,
    S_OUT    = 11'b100_0000_0000
  } state_t;

  // clamp a wide signed value to the sample range
  function automatic logic signed [SMP_W-1:0] sat_smp(input logic signed [31:0] x);
    logic signed [31:0] hi;
    logic signed [31:0] lo;
    hi = 32'sd8388607;
    lo = -32'sd8388608;
    if (x > hi) begin
      sat_smp = SMP_W'(hi);
    end else if (x < lo) begin
      sat_smp = SMP_W'(lo);
    end else begin
      sat_smp = SMP_W'(x);
    end
  endfunction

endpackage

// ===== rtl/msfd_ring_ram.sv =====
// ----------------------------------------------------------------------------
// msfd_ring_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module msfd_ring_ram #(
  parameter int AW = 18,
  parameter int DW = 24
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [1 << AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/multitap_stereo_feedback_delay.sv =====
// ----------------------------------------------------------------------------
// multitap_stereo_feedback_delay
// Stereo multitap delay with fractional taps, feedback and dry/wet mix.
// ----------------------------------------------------------------------------
//  channel | handshake                  | payload
//  --------+----------------------------+-------------------------------------
//  in      | in_valid / in_stall        | left_in, right_in, mono_input
//  out     | out_valid / out_stall      | left_out, right_out
//  cfg     | cfg_write (no wait)        | cfg_index, cfg_data
//
//  The time per word grows with the tap count through the tap loop: each tap
//  reads both neighbours through the single read port of each ring RAM.
//  Ring contents read as zero after reset without a clearing pass: entries
//  are written in address order, so a fill count marks those not yet written.
//  A stalled result waits in the output register; the next input word is
//  taken meanwhile, and the block holds in its final step until room appears.
// ----------------------------------------------------------------------------
module multitap_stereo_feedback_delay (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [msfd_pkg::SMP_W-1:0]   left_in,
  input  logic signed [msfd_pkg::SMP_W-1:0]   right_in,
  input  logic                                mono_input,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [msfd_pkg::SMP_W-1:0]   left_out,
  output logic signed [msfd_pkg::SMP_W-1:0]   right_out,
  input  logic                                cfg_write,
  input  logic [msfd_pkg::CFG_IW-1:0]         cfg_index,
  input  logic [msfd_pkg::CFG_DW-1:0]         cfg_data
);

  `include "multitap_stereo_feedback_delay_assert.svh"

  localparam int AW = msfd_pkg::RING_AW;
  localparam int SW = msfd_pkg::SMP_W;

  // configuration registers
  logic [2:0]                tap_count;
  logic [55:0]               tap_word [msfd_pkg::NUM_TAPS];
  logic [15:0]               feedback_target;
  logic [15:0]               mix_target;
  logic [15:0]               smooth_coef;

  // control state
  msfd_pkg::state_t          state;
  logic [AW-1:0]             write_position;
  logic [AW:0]               fill;
  logic [23:0]               feedback_now;
  logic [23:0]               mix_now;
  logic [msfd_pkg::TAP_IW-1:0] tap_idx;
  logic                      rd_ok;

  // datapath registers
  logic signed [SW-1:0]      inl;
  logic signed [SW-1:0]      inr;
  logic signed [41:0]        g_fb;
  logic signed [41:0]        g_mx;
  logic signed [SW-1:0]      a_l;
  logic signed [SW-1:0]      a_r;
  logic signed [SW:0]        s_sum;
  logic signed [41:0]        p_l;
  logic signed [41:0]        p_r;
  logic signed [42:0]        acc_l;
  logic signed [42:0]        acc_r;
  logic signed [51:0]        p_fbl;
  logic signed [51:0]        p_fbr;
  logic signed [49:0]        p_dryl;
  logic signed [49:0]        p_dryr;
  logic signed [51:0]        p_wml;
  logic signed [51:0]        p_wmr;

  // ---------------------------------------------------------------- taps
  logic [2:0]                taps_eff;
  logic [55:0]               tw;
  logic [23:0]               delay;
  logic [5:0]                frac;
  logic [5:0]                fw;
  logic [AW-1:0]             base;
  logic [AW-1:0]             i0;
  logic [AW-1:0]             i1;
  logic [AW-1:0]             raddr;
  logic [SW-1:0]             rdata_l;
  logic [SW-1:0]             rdata_r;
  logic signed [SW-1:0]      b_l;
  logic signed [SW-1:0]      b_r;
  logic signed [SW:0]        d_l;
  logic signed [SW:0]        d_r;
  logic signed [31:0]        m_l;
  logic signed [31:0]        m_r;
  logic signed [SW-1:0]      il;
  logic signed [SW-1:0]      ir;
  logic                      last_tap;

  // clip the tap count to the available tap words
  assign taps_eff = (tap_count > 3'(msfd_pkg::NUM_TAPS)) ?
                    3'(msfd_pkg::NUM_TAPS) : tap_count;
  assign tw       = tap_word[tap_idx];
  assign delay    = tw[55:32];
  assign frac     = delay[5:0];
  // integer delay wraps modulo the ring depth
  assign base     = write_position - AW'(delay[23:6]);
  assign i0       = (frac != 6'd0) ? base - AW'(1) : base;
  assign i1       = i0 + AW'(1);
  assign fw       = (frac != 6'd0) ? 6'(7'd64 - {1'b0, frac}) : 6'd0;
  assign raddr    = (state == msfd_pkg::S_RD1) ? i1 : i0;
  assign last_tap = (3'(tap_idx) + 3'd1) == taps_eff;

  // unwritten entries read as zero
  assign b_l = rd_ok ? $signed(rdata_l) : '0;
  assign b_r = rd_ok ? $signed(rdata_r) : '0;
  assign d_l = $signed({b_l[SW-1], b_l}) - $signed({a_l[SW-1], a_l});
  assign d_r = $signed({b_r[SW-1], b_r}) - $signed({a_r[SW-1], a_r});
  assign m_l = d_l * $signed({1'b0, fw});
  assign m_r = d_r * $signed({1'b0, fw});
  assign il  = SW'($signed({a_l[SW-1], a_l}) + m_l[31:6]);
  assign ir  = SW'($signed({a_r[SW-1], a_r}) + m_r[31:6]);

  // -------------------------------------------------------------- glide
  logic signed [24:0]        diff_fb;
  logic signed [24:0]        diff_mx;
  logic signed [41:0]        rnd_fb;
  logic signed [41:0]        rnd_mx;
  logic signed [25:0]        fb_sum;
  logic signed [25:0]        mx_sum;

  assign diff_fb = $signed({1'b0, feedback_target, 8'h00}) - $signed({1'b0, feedback_now});
  assign diff_mx = $signed({1'b0, mix_target, 8'h00}) - $signed({1'b0, mix_now});
  // round half up, then floor
  assign rnd_fb  = g_fb + 42'sd32768;
  assign rnd_mx  = g_mx + 42'sd32768;
  assign fb_sum  = $signed({2'b00, feedback_now}) + rnd_fb[41:16];
  assign mx_sum  = $signed({2'b00, mix_now}) + rnd_mx[41:16];

  // ---------------------------------------------------------- wet / mix
  logic signed [26:0]        wet_l;
  logic signed [26:0]        wet_r;
  logic signed [25:0]        dry;
  logic signed [29:0]        wr_l;
  logic signed [29:0]        wr_r;
  logic signed [52:0]        o_l;
  logic signed [52:0]        o_r;
  logic                      ram_we;
  logic [SW-1:0]             wdata_l;
  logic [SW-1:0]             wdata_r;
  logic                      out_free;

  assign wet_l   = acc_l[42:16];
  assign wet_r   = acc_r[42:16];
  // dry weight goes negative once the mix passes unity
  assign dry     = 26'sd8388608 - $signed({2'b00, mix_now});
  assign wr_l    = $signed({{6{inl[SW-1]}}, inl}) + $signed(p_fbl[51:23]);
  assign wr_r    = $signed({{6{inr[SW-1]}}, inr}) + $signed(p_fbr[51:23]);
  assign wdata_l = msfd_pkg::sat_smp(32'(wr_l));
  assign wdata_r = msfd_pkg::sat_smp(32'(wr_r));
  assign o_l     = 53'(p_dryl) + 53'(p_wml);
  assign o_r     = 53'(p_dryr) + 53'(p_wmr);
  assign ram_we  = (state == msfd_pkg::S_MIX);
  assign out_free = !out_valid || !out_stall;

  assign in_stall = (state != msfd_pkg::S_IDLE);

  // ---------------------------------------------------------- ring RAMs
  msfd_ring_ram #(.AW(AW), .DW(SW)) u_ring_l (
    .clk   (clk),
    .we    (ram_we),
    .waddr (write_position),
    .wdata (wdata_l),
    .raddr (raddr),
    .rdata (rdata_l)
  );

  msfd_ring_ram #(.AW(AW), .DW(SW)) u_ring_r (
    .clk   (clk),
    .we    (ram_we),
    .waddr (write_position),
    .wdata (wdata_r),
    .raddr (raddr),
    .rdata (rdata_r)
  );

  // ------------------------------------------------------ configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      tap_count       <= '0;
      feedback_target <= '0;
      mix_target      <= '0;
      smooth_coef     <= msfd_pkg::SMOOTH_RESET;
      for (int k = 0; k < msfd_pkg::NUM_TAPS; k++) begin
        tap_word[k] <= '0;
      end
    end else if (cfg_write) begin
      case (cfg_index)
        msfd_pkg::REG_TAP_COUNT:  tap_count       <= cfg_data[2:0];
        msfd_pkg::REG_FB_TARGET:  feedback_target <= cfg_data[15:0];
        msfd_pkg::REG_MIX_TARGET: mix_target      <= cfg_data[15:0];
        msfd_pkg::REG_SMOOTH:     smooth_coef     <= cfg_data[15:0];
        default: begin
          // tap words sit at consecutive indexes; anything else is dropped
          if (cfg_index >= msfd_pkg::REG_TAP_0 && cfg_index <= msfd_pkg::REG_TAP_3) begin
            tap_word[msfd_pkg::TAP_IW'(cfg_index - msfd_pkg::REG_TAP_0)] <= cfg_data;
          end
        end
      endcase
    end
  end

  // ----------------------------------------------------------- sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= msfd_pkg::S_IDLE;
      write_position <= '0;
      fill           <= '0;
      feedback_now   <= '0;
      mix_now        <= '0;
      tap_idx        <= '0;
      rd_ok          <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      // the read flag is registered from the read address, in step with the registered RAM read data
      rd_ok <= ({1'b0, raddr} < fill);
      // raise on a finished word once there is room, drop once taken
      if (state == msfd_pkg::S_OUT && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        msfd_pkg::S_IDLE: begin
          if (in_valid) begin
            state <= msfd_pkg::S_GLIDE;
          end
        end
        msfd_pkg::S_GLIDE: begin
          state <= msfd_pkg::S_GUPD;
        end
        msfd_pkg::S_GUPD: begin
          feedback_now <= fb_sum[23:0];
          mix_now      <= mx_sum[23:0];
          tap_idx      <= '0;
          state        <= (taps_eff == 3'd0) ? msfd_pkg::S_WET : msfd_pkg::S_RD0;
        end
        msfd_pkg::S_RD0:    state <= msfd_pkg::S_RD1;
        msfd_pkg::S_RD1:    state <= msfd_pkg::S_INTERP;
        msfd_pkg::S_INTERP: state <= msfd_pkg::S_MAC;
        msfd_pkg::S_MAC:    state <= msfd_pkg::S_ACC;
        msfd_pkg::S_ACC: begin
          tap_idx <= tap_idx + msfd_pkg::TAP_IW'(1);
          state   <= last_tap ? msfd_pkg::S_WET : msfd_pkg::S_RD0;
        end
        msfd_pkg::S_WET: state <= msfd_pkg::S_MIX;
        msfd_pkg::S_MIX: begin
          write_position <= write_position + AW'(1);
          if (fill != (AW+1)'(msfd_pkg::RING_DEPTH)) begin
            fill <= fill + (AW+1)'(1);
          end
          state <= msfd_pkg::S_OUT;
        end
        msfd_pkg::S_OUT: begin
          // hold until the output register has room
          if (out_free) begin
            state <= msfd_pkg::S_IDLE;
          end
        end
        default: state <= msfd_pkg::S_IDLE;
      endcase
    end
  end

  // ------------------------------------------------------------ datapath
  always_ff @(posedge clk) begin
    case (state)
      msfd_pkg::S_IDLE: begin
        if (in_valid) begin
          inl <= left_in;
          inr <= mono_input ? left_in : right_in;
        end
        acc_l <= '0;
        acc_r <= '0;
      end
      msfd_pkg::S_GLIDE: begin
        g_fb <= diff_fb * $signed({1'b0, smooth_coef});
        g_mx <= diff_mx * $signed({1'b0, smooth_coef});
      end
      msfd_pkg::S_RD1: begin
        a_l <= rd_ok ? $signed(rdata_l) : '0;
        a_r <= rd_ok ? $signed(rdata_r) : '0;
      end
      msfd_pkg::S_INTERP: begin
        s_sum <= $signed({il[SW-1], il}) + $signed({ir[SW-1], ir});
      end
      msfd_pkg::S_MAC: begin
        p_l <= s_sum * $signed({1'b0, tw[31:16]});
        p_r <= s_sum * $signed({1'b0, tw[15:0]});
      end
      msfd_pkg::S_ACC: begin
        acc_l <= acc_l + 43'(p_l);
        acc_r <= acc_r + 43'(p_r);
      end
      msfd_pkg::S_WET: begin
        p_fbl  <= wet_l * $signed({1'b0, feedback_now});
        p_fbr  <= wet_r * $signed({1'b0, feedback_now});
        p_dryl <= inl * dry;
        p_dryr <= inr * dry;
      end
      msfd_pkg::S_MIX: begin
        p_wml <= wet_l * $signed({1'b0, mix_now});
        p_wmr <= wet_r * $signed({1'b0, mix_now});
      end
      msfd_pkg::S_OUT: begin
        if (out_free) begin
          left_out  <= msfd_pkg::sat_smp(32'($signed(o_l[52:23])));
          right_out <= msfd_pkg::sat_smp(32'($signed(o_r[52:23])));
        end
      end
      default: begin
      end
    endcase
  end

  // ---------------------------------------------------------- assertions
  `MSFD_ASSERT_SAME(a_fill_bound, 1'b1, fill <= (AW+1)'(msfd_pkg::RING_DEPTH))
  `MSFD_ASSERT_SAME(a_out_from_final, $rose(out_valid), $past(state == msfd_pkg::S_OUT))
  `MSFD_ASSERT_NEXT(a_wp_step, state == msfd_pkg::S_MIX, write_position == $past(write_position) + AW'(1))
  `MSFD_ASSERT_SAME(a_tap_range, state == msfd_pkg::S_RD0, 3'(tap_idx) < taps_eff)

endmodule
